FILE: hw/rtl/csh_pkg.sv
// ============================================================================
// csh_pkg
// Shared constants, codes and types of the calibrated spectrum histogrammer.
// ============================================================================
package csh_pkg;

  // Sizing
  localparam int NUM_DETECTORS = 32;
  localparam int ENERGY_BINS   = 2048;
  localparam int TIME_BINS     = 512;
  localparam int COUNT_WIDTH   = 32;

  // Fixed field widths
  localparam int REQ_W   = 3;
  localparam int DETF_W  = 5;
  localparam int RAW_W   = 12;
  localparam int DITH_W  = 8;
  localparam int ADDRF_W = 11;
  localparam int GAIN_W  = 16;
  localparam int SHIFT_W = 16;
  localparam int IDX_W   = 11;
  localparam int CNT_W   = 32;

  localparam int DET_IDX_W = (NUM_DETECTORS > 1) ? $clog2(NUM_DETECTORS) : 1;
  localparam int EBIN_W    = $clog2(ENERGY_BINS);
  localparam int TBIN_W    = $clog2(TIME_BINS);
  localparam int E_DEPTH   = NUM_DETECTORS * ENERGY_BINS;
  localparam int T_DEPTH   = NUM_DETECTORS * TIME_BINS;
  localparam int EADDR_W   = DET_IDX_W + EBIN_W;
  localparam int TADDR_W   = DET_IDX_W + TBIN_W;

  // Fixed point: v = raw*256 + dither (Q.8), energy sum in 2^-21, time sum in 2^-12
  localparam int V_W        = RAW_W + DITH_W + 1;
  localparam int PROD_W     = V_W + GAIN_W + 1;
  localparam int ES_W       = PROD_W + 2;
  localparam int TS_W       = SHIFT_W + DITH_W + 2;
  localparam int E_FRAC     = 21;
  localparam int T_FRAC     = 12;
  localparam int E_SHIFT_POS = E_FRAC - 4;
  localparam int T_SHIFT_POS = T_FRAC - 4;

  localparam logic signed [ES_W-1:0] E_ROUND = ES_W'(1) <<< (E_FRAC - 1);
  localparam logic signed [TS_W-1:0] T_ROUND = TS_W'(1) <<< (T_FRAC - 1);

  localparam logic [GAIN_W-1:0]      UNITY_GAIN = GAIN_W'(4096);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_E_HIT  = 3'd0,
    REQ_T_HIT  = 3'd1,
    REQ_E_READ = 3'd2,
    REQ_T_READ = 3'd3,
    REQ_E_LOAD = 3'd4,
    REQ_T_LOAD = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_BIN,
    S_WB
  } state_t;

  // Calibration table write request
  typedef struct packed {
    logic                 e_we;
    logic                 t_we;
    logic [DET_IDX_W-1:0] det;
    logic [GAIN_W-1:0]    gain;
    logic [SHIFT_W-1:0]   shift;
  } cal_wr_t;

  // Calibration entry of one detector
  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [SHIFT_W-1:0] e_shift;
    logic [SHIFT_W-1:0] t_shift;
  } cal_rd_t;

endpackage

FILE: hw/rtl/csh_ifs.sv
// ============================================================================
// csh channel interfaces
// Valid/ready channels for requests and results.
// ============================================================================
interface csh_in_if;
  logic                valid;
  logic                ready;
  logic [2:0]          req_type;
  logic [4:0]          detector;
  logic [11:0]         raw_value;
  logic signed [7:0]   dither;
  logic [10:0]         bin_address;
  logic [15:0]         gain_value;
  logic signed [15:0]  shift_value;

  modport source (output valid, req_type, detector, raw_value, dither, bin_address,
                  gain_value, shift_value, input ready);
  modport sink   (input valid, req_type, detector, raw_value, dither, bin_address,
                  gain_value, shift_value, output ready);
endinterface

interface csh_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] bin_index;
  logic [31:0] bin_count;
  logic        out_of_range;
  logic        saturated;

  modport source (output valid, bin_index, bin_count, out_of_range, saturated,
                  input ready);
  modport sink   (input valid, bin_index, bin_count, out_of_range, saturated,
                  output ready);
endinterface

FILE: hw/rtl/csh_cal_tbl.sv
// ============================================================================
// csh_cal_tbl
// Per-detector gain and shift registers, reset to unity gain and zero shift.
// ============================================================================
module csh_cal_tbl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csh_pkg::cal_wr_t              wr,
  input  logic [csh_pkg::DET_IDX_W-1:0] rd_det,
  output csh_pkg::cal_rd_t              rd
);
  import csh_pkg::*;

  logic [GAIN_W-1:0]  gain_r    [NUM_DETECTORS];
  logic [SHIFT_W-1:0] e_shift_r [NUM_DETECTORS];
  logic [SHIFT_W-1:0] t_shift_r [NUM_DETECTORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        gain_r[i]    <= UNITY_GAIN;
        e_shift_r[i] <= '0;
        t_shift_r[i] <= '0;
      end
    end else begin
      if (wr.e_we) begin
        gain_r[wr.det]    <= wr.gain;
        e_shift_r[wr.det] <= wr.shift;
      end
      if (wr.t_we) begin
        t_shift_r[wr.det] <= wr.shift;
      end
    end
  end

  assign rd.gain    = gain_r[rd_det];
  assign rd.e_shift = e_shift_r[rd_det];
  assign rd.t_shift = t_shift_r[rd_det];

endmodule

FILE: hw/rtl/csh_ram.sv
// ============================================================================
// csh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module csh_ram #(
  parameter  int DEPTH  = 1024,
  parameter  int WIDTH  = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/calibrated_spectrum_histogrammer.sv
// ============================================================================
// calibrated_spectrum_histogrammer
// Gain/shift calibrated energy and time histograms per detector, counts in RAM.
// ============================================================================
//  channel | dir | payload                                              | transfer
//  --------+-----+------------------------------------------------------+------------------
//  in_chan | in  | req_type detector raw_value dither bin_address gain  | valid & ready
//          |     | shift_value                                          |
//  out_chan| out | bin_index bin_count out_of_range saturated           | valid & ready
//
//  A request passes through accept, gain multiply, bin compute and RAM
//  read, then count update / write-back into the result register.
//  The single read-modify-write path through the RAMs allows one request at a time.
//  After reset a clearing pass zeroes the RAMs, sweeping E_DEPTH (65536) addresses,
//  with in_chan.ready low.
//  A held result stalls write-back until out_chan frees the result register;
//  the next request is accepted while a result waits.
// ============================================================================
module calibrated_spectrum_histogrammer (
  input logic      clk,
  input logic      rst_n,
  csh_in_if.sink   in_chan,
  csh_out_if.source out_chan
);
  import csh_pkg::*;

  state_t state_r, state_nxt;
  logic [EADDR_W-1:0] clr_cnt_r;

  // Captured request
  logic [REQ_W-1:0]   req_r;
  logic [DETF_W-1:0]  det_r;
  logic [RAW_W-1:0]   raw_r;
  logic [DITH_W-1:0]  dith_r;
  logic [ADDRF_W-1:0] addr_r;
  logic [GAIN_W-1:0]  gain_in_r;
  logic [SHIFT_W-1:0] shift_in_r;

  // Multiply stage
  logic signed [V_W-1:0]    v_r;
  logic signed [PROD_W-1:0] e_prod_r;
  logic [SHIFT_W-1:0]       e_shift_r;
  logic [SHIFT_W-1:0]       t_shift_r;

  // Bin stage
  logic [IDX_W-1:0] bin_r, bin_nxt;
  logic             oor_r, oor_nxt;
  logic             use_mem_r, use_mem_nxt;
  logic             hit_r, hit_nxt;

  // Result register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_oor_r;
  logic             out_sat_r;

  logic                 det_ok;
  logic [DET_IDX_W-1:0] det_idx;
  logic                 in_fire, wb_fire, out_free;
  logic                 is_energy;

  cal_wr_t cal_wr;
  cal_rd_t cal_rd;

  logic signed [V_W-1:0]    v;
  logic signed [PROD_W-1:0] e_prod;
  logic signed [ES_W-1:0]   e_sum, e_q;
  logic signed [TS_W-1:0]   t_sum, t_q;
  logic                     e_ok, t_ok;
  logic [EBIN_W-1:0]        e_bin;
  logic [TBIN_W-1:0]        t_bin;

  logic                   e_we, t_we, e_re, t_re;
  logic [EADDR_W-1:0]     e_waddr, e_raddr;
  logic [TADDR_W-1:0]     t_waddr, t_raddr;
  logic [COUNT_WIDTH-1:0] e_wdata, t_wdata, e_rdata, t_rdata;
  logic [COUNT_WIDTH-1:0] cnt_rd, cnt_new;
  logic                   cnt_sat, cnt_wr;

  assign det_ok   = int'(det_r) < NUM_DETECTORS;
  assign det_idx  = DET_IDX_W'(det_r);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign wb_fire  = (state_r == S_WB) && out_free;
  assign is_energy = (req_r == REQ_E_HIT) || (req_r == REQ_E_READ);

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + EADDR_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == EADDR_W'(E_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_BIN;
      S_BIN: state_nxt = S_WB;
      S_WB: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // -------------------------------------------------------------------------
  // Request capture and calibration
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r      <= in_chan.req_type;
      det_r      <= in_chan.detector;
      raw_r      <= in_chan.raw_value;
      dith_r     <= in_chan.dither;
      addr_r     <= in_chan.bin_address;
      gain_in_r  <= in_chan.gain_value;
      shift_in_r <= in_chan.shift_value;
    end
  end

  csh_cal_tbl u_cal (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (cal_wr),
    .rd_det (det_idx),
    .rd     (cal_rd)
  );

  always_comb begin
    cal_wr.e_we  = (state_r == S_MUL) && det_ok && (req_r == REQ_E_LOAD);
    cal_wr.t_we  = (state_r == S_MUL) && det_ok && (req_r == REQ_T_LOAD);
    cal_wr.det   = det_idx;
    cal_wr.gain  = gain_in_r;
    cal_wr.shift = shift_in_r;
  end

  assign v      = $signed({1'b0, raw_r, 8'h00}) + V_W'($signed(dith_r));
  assign e_prod = PROD_W'(v) * PROD_W'($signed({1'b0, cal_rd.gain}));

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      v_r       <= v;
      e_prod_r  <= e_prod;
      e_shift_r <= cal_rd.e_shift;
      t_shift_r <= cal_rd.t_shift;
    end
  end

  // -------------------------------------------------------------------------
  // Bin: round, truncate toward zero, range check
  // -------------------------------------------------------------------------
  assign e_sum = ES_W'(e_prod_r) + (ES_W'($signed(e_shift_r)) <<< E_SHIFT_POS) + E_ROUND;
  assign t_sum = TS_W'(v_r) + (TS_W'($signed(t_shift_r)) <<< T_SHIFT_POS) + T_ROUND;
  assign e_q   = e_sum >>> E_FRAC;
  assign t_q   = t_sum >>> T_FRAC;

  // A negative sum above -1 truncates to bin 0 and stays in range
  always_comb begin
    if (e_sum[ES_W-1]) begin
      e_ok  = (e_q == '1) && (|e_sum[E_FRAC-1:0]);
      e_bin = '0;
    end else begin
      e_ok  = e_q < ES_W'(ENERGY_BINS);
      e_bin = e_q[EBIN_W-1:0];
    end
    if (t_sum[TS_W-1]) begin
      t_ok  = (t_q == '1) && (|t_sum[T_FRAC-1:0]);
      t_bin = '0;
    end else begin
      t_ok  = t_q < TS_W'(TIME_BINS);
      t_bin = t_q[TBIN_W-1:0];
    end
  end

  always_comb begin
    bin_nxt     = '0;
    oor_nxt     = 1'b0;
    use_mem_nxt = 1'b0;
    hit_nxt     = 1'b0;
    unique case (req_r)
      REQ_E_HIT: begin
        hit_nxt     = 1'b1;
        use_mem_nxt = 1'b1;
        oor_nxt     = !e_ok;
        bin_nxt     = e_ok ? IDX_W'(e_bin) : '0;
      end
      REQ_T_HIT: begin
        hit_nxt     = 1'b1;
        use_mem_nxt = 1'b1;
        oor_nxt     = !t_ok;
        bin_nxt     = t_ok ? IDX_W'(t_bin) : '0;
      end
      REQ_E_READ: begin
        bin_nxt     = IDX_W'(addr_r);
        use_mem_nxt = int'(addr_r) < ENERGY_BINS;
        oor_nxt     = !use_mem_nxt;
      end
      REQ_T_READ: begin
        bin_nxt     = IDX_W'(addr_r);
        use_mem_nxt = int'(addr_r) < TIME_BINS;
        oor_nxt     = !use_mem_nxt;
      end
      default: ;
    endcase
    // Unknown detector: hits and reads report bin 0 out of range
    if (!det_ok) begin
      bin_nxt     = '0;
      oor_nxt     = (req_r == REQ_E_HIT) || (req_r == REQ_T_HIT) ||
                    (req_r == REQ_E_READ) || (req_r == REQ_T_READ);
      use_mem_nxt = 1'b0;
      hit_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_BIN) begin
      bin_r     <= bin_nxt;
      oor_r     <= oor_nxt;
      use_mem_r <= use_mem_nxt;
      hit_r     <= hit_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Histogram RAMs: clear sweep, read in bin stage, write back
  // -------------------------------------------------------------------------
  assign e_re    = (state_r == S_BIN) && use_mem_nxt && is_energy;
  assign t_re    = (state_r == S_BIN) && use_mem_nxt && !is_energy;
  assign e_raddr = {det_idx, bin_nxt[EBIN_W-1:0]};
  assign t_raddr = {det_idx, bin_nxt[TBIN_W-1:0]};

  assign cnt_rd  = is_energy ? e_rdata : t_rdata;
  assign cnt_sat = use_mem_r && (cnt_rd == COUNT_MAX);
  assign cnt_new = cnt_sat ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);
  assign cnt_wr  = wb_fire && hit_r && !cnt_sat;

  always_comb begin
    if (state_r == S_CLEAR) begin
      e_we    = 1'b1;
      e_waddr = clr_cnt_r;
      e_wdata = '0;
      t_we    = int'(clr_cnt_r) < T_DEPTH;
      t_waddr = clr_cnt_r[TADDR_W-1:0];
      t_wdata = '0;
    end else begin
      e_we    = cnt_wr && is_energy;
      e_waddr = {det_idx, bin_r[EBIN_W-1:0]};
      e_wdata = cnt_new;
      t_we    = cnt_wr && !is_energy;
      t_waddr = {det_idx, bin_r[TBIN_W-1:0]};
      t_wdata = cnt_new;
    end
  end

  csh_ram #(.DEPTH(E_DEPTH), .WIDTH(COUNT_WIDTH)) u_e_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  csh_ram #(.DEPTH(T_DEPTH), .WIDTH(COUNT_WIDTH)) u_t_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_idx_r <= bin_r;
      out_oor_r <= oor_r;
      out_sat_r <= cnt_sat;
      if (!use_mem_r) begin
        out_cnt_r <= '0;
      end else if (hit_r) begin
        out_cnt_r <= CNT_W'(cnt_new);
      end else begin
        out_cnt_r <= CNT_W'(cnt_rd);
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.bin_index    = out_idx_r;
  assign out_chan.bin_count    = out_cnt_r;
  assign out_chan.out_of_range = out_oor_r;
  assign out_chan.saturated    = out_sat_r;

endmodule

FILE: hw/rtl/csh_checker.sv
// ============================================================================
// csh_checker
// Port-level checks of the histogrammer, bound to the top level.
// ============================================================================
module csh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_bin_index,
  input logic [31:0] out_bin_count,
  input logic        out_oor,
  input logic        out_sat
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_index) &&
      $stable(out_bin_count) && $stable(out_oor) && $stable(out_sat))
    else $error("result changed while stalled");

  // Clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during clearing pass");

  // One request in flight: no accept right after an accept, no early result
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("request overlap or early result");

  // A saturated bin reports a full count, and bin 0 if out of range
  a_sat_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sat |-> (&out_bin_count) && !(out_oor && out_bin_index != 11'd0))
    else $error("saturated flag without full count");

endmodule

bind calibrated_spectrum_histogrammer csh_checker u_csh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_bin_index (out_chan.bin_index),
  .out_bin_count (out_chan.bin_count),
  .out_oor       (out_chan.out_of_range),
  .out_sat       (out_chan.saturated)
);

FILE: tb/hist_checker.sv
// ============================================================================
// hist_checker
// Watches the request and result channels, keeps its own copy of the
// calibration tables and histogram counts, and checks every result in order.
// ============================================================================
module hist_checker (
  input  logic clk,
  input  logic rst_n,
  csh_in_if    in_mon,
  csh_out_if   out_mon,
  output int   pending,
  output int   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import csh_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
    logic             oor;
    logic             sat;
  } bin_report_t;

  bin_report_t expected_bins[$];

  logic [COUNT_WIDTH-1:0]    e_counts    [E_DEPTH];
  logic [COUNT_WIDTH-1:0]    t_counts    [T_DEPTH];
  logic [GAIN_W-1:0]         gain_tab    [NUM_DETECTORS];
  logic signed [SHIFT_W-1:0] e_shift_tab [NUM_DETECTORS];
  logic signed [SHIFT_W-1:0] t_shift_tab [NUM_DETECTORS];

  function automatic longint toward_zero(longint s, int k);
    return (s >= 0) ? (s >>> k) : -((-s) >>> k);
  endfunction

  function automatic bin_report_t count_bin(bit energy, int det, longint b);
    bin_report_t            r;
    int                     nbins;
    int                     slot;
    logic [COUNT_WIDTH-1:0] c;
    r     = '0;
    nbins = energy ? ENERGY_BINS : TIME_BINS;
    // anything off the spectrum lands in bin 0
    if (b < 0 || b > nbins - 1) begin
      b     = 0;
      r.oor = 1'b1;
    end
    slot = det * nbins + int'(b);
    c    = energy ? e_counts[slot] : t_counts[slot];
    if (c == COUNT_MAX) r.sat = 1'b1;
    else c = c + 1'b1;
    if (energy) e_counts[slot] = c;
    else t_counts[slot] = c;
    r.idx = IDX_W'(b);
    r.cnt = CNT_W'(c);
    return r;
  endfunction

  function automatic bin_report_t read_count(bit energy, int det, logic [ADDRF_W-1:0] addr);
    bin_report_t            r;
    int                     nbins;
    logic [COUNT_WIDTH-1:0] c;
    r     = '0;
    r.idx = addr;
    nbins = energy ? ENERGY_BINS : TIME_BINS;
    if (int'(addr) >= nbins) begin
      r.oor = 1'b1;
    end else begin
      c     = energy ? e_counts[det * nbins + int'(addr)] : t_counts[det * nbins + int'(addr)];
      r.cnt = CNT_W'(c);
      r.sat = (c == COUNT_MAX);
    end
    return r;
  endfunction

  function automatic bin_report_t tally_request(
    logic [REQ_W-1:0]          req,
    logic [DETF_W-1:0]         det,
    logic [RAW_W-1:0]          raw,
    logic signed [DITH_W-1:0]  dith,
    logic [ADDRF_W-1:0]        addr,
    logic [GAIN_W-1:0]         gain,
    logic signed [SHIFT_W-1:0] shv
  );
    bin_report_t r;
    longint      v;
    longint      s;
    int          d;
    r = '0;
    d = int'(det);
    v = longint'(raw) * 256 + longint'(dith);
    if (req > REQ_T_LOAD) return r;
    if (d >= NUM_DETECTORS) begin
      if (req <= REQ_T_READ) r.oor = 1'b1;
      return r;
    end
    case (req)
      REQ_E_HIT: begin
        s = v * longint'(gain_tab[d])
            + longint'(e_shift_tab[d]) * (longint'(1) <<< E_SHIFT_POS)
            + (longint'(1) <<< (E_FRAC - 1));
        r = count_bin(1'b1, d, toward_zero(s, E_FRAC));
      end
      REQ_T_HIT: begin
        s = v + longint'(t_shift_tab[d]) * (longint'(1) <<< T_SHIFT_POS)
            + (longint'(1) <<< (T_FRAC - 1));
        r = count_bin(1'b0, d, toward_zero(s, T_FRAC));
      end
      REQ_E_READ: r = read_count(1'b1, d, addr);
      REQ_T_READ: r = read_count(1'b0, d, addr);
      REQ_E_LOAD: begin
        gain_tab[d]    = gain;
        e_shift_tab[d] = shv;
      end
      default: t_shift_tab[d] = shv;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    bin_report_t want;
    bin_report_t got;
    if (!rst_n) begin
      for (int i = 0; i < E_DEPTH; i++) e_counts[i] = '0;
      for (int i = 0; i < T_DEPTH; i++) t_counts[i] = '0;
      for (int i = 0; i < NUM_DETECTORS; i++) begin
        gain_tab[i]    = UNITY_GAIN;
        e_shift_tab[i] = '0;
        t_shift_tab[i] = '0;
      end
      expected_bins.delete();
      mismatches = 0;
    end else begin
      // retire the result first: it can never belong to a request taken this edge
      if (out_mon.valid && out_mon.ready) begin
        got.idx = out_mon.bin_index;
        got.cnt = out_mon.bin_count;
        got.oor = out_mon.out_of_range;
        got.sat = out_mon.saturated;
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result bin_index %0d bin_count %0d oor %0b sat %0b",
                     $realtime, got.idx, got.cnt, got.oor, got.sat);
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch bin_index %0d/%0d bin_count %0d/%0d oor %0b/%0b sat %0b/%0b (exp/act)",
                       $realtime, want.idx, got.idx, want.cnt, got.cnt, want.oor, got.oor,
                       want.sat, got.sat);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_bins.push_back(tally_request(in_mon.req_type, in_mon.detector,
                                              in_mon.raw_value, in_mon.dither,
                                              in_mon.bin_address, in_mon.gain_value,
                                              in_mon.shift_value));
    end
    pending <= expected_bins.size();
  end

endmodule

FILE: tb/tb_top.sv
// ============================================================================
// tb_top
// Drives directed and random detector hits, bin reads and calibration loads
// into the histogrammer with random gaps and result back-pressure; the
// checker beside the block predicts and compares every result.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csh_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT = 10000;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic [DETF_W-1:0]         det;
    logic [RAW_W-1:0]          raw;
    logic signed [DITH_W-1:0]  dith;
    logic [ADDRF_W-1:0]        addr;
    logic [GAIN_W-1:0]         gain;
    logic signed [SHIFT_W-1:0] shv;
  } hist_req_t;

  typedef struct {
    logic [DETF_W-1:0] det;
    logic [RAW_W-1:0]  raw;
  } hit_rec_t;

  logic clk;
  logic rst_n;
  int   results_pending;
  int   mismatch_count;
  int   holds_asked = 0;
  bit   src_steady  = 1'b0;
  bit   sink_steady = 1'b0;

  hit_rec_t e_recent_hits[$];
  hit_rec_t t_recent_hits[$];

  csh_in_if  req_if ();
  csh_out_if res_if ();

  calibrated_spectrum_histogrammer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (res_if)
  );

  hist_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (req_if),
    .out_mon    (res_if),
    .pending    (results_pending),
    .mismatches (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic hist_req_t mk(logic [REQ_W-1:0] req, int det, int raw, int dith,
                                   int addr, int gain, int shv);
    hist_req_t r;
    r.req  = req;
    r.det  = DETF_W'(det);
    r.raw  = RAW_W'(raw);
    r.dith = DITH_W'(dith);
    r.addr = ADDRF_W'(addr);
    r.gain = GAIN_W'(gain);
    r.shv  = SHIFT_W'(shv);
    return r;
  endfunction

  function automatic hist_req_t random_request();
    hist_req_t r;
    hit_rec_t  h;
    int        pick;
    r.det  = ($urandom_range(99) < 60) ? DETF_W'($urandom_range(3)) : DETF_W'($urandom_range(31));
    r.raw  = RAW_W'($urandom);
    r.dith = DITH_W'($urandom);
    r.addr = ADDRF_W'($urandom);
    r.gain = GAIN_W'($urandom);
    r.shv  = SHIFT_W'($urandom);
    pick   = $urandom_range(99);
    if (pick < 35) begin
      r.req = REQ_E_HIT;
    end else if (pick < 60) begin
      r.req = REQ_T_HIT;
    end else if (pick < 75) begin
      r.req = REQ_E_READ;
      // mostly read back bins that were likely hit
      if (e_recent_hits.size() > 0 && $urandom_range(99) < 70) begin
        h      = e_recent_hits[$urandom_range(e_recent_hits.size() - 1)];
        r.det  = h.det;
        r.addr = ADDRF_W'(h.raw >> 1);
      end
    end else if (pick < 85) begin
      r.req = REQ_T_READ;
      if (t_recent_hits.size() > 0 && $urandom_range(99) < 60) begin
        h      = t_recent_hits[$urandom_range(t_recent_hits.size() - 1)];
        r.det  = h.det;
        r.addr = ADDRF_W'(h.raw >> 4);
      end else if ($urandom_range(1) == 0) begin
        r.addr = ADDRF_W'($urandom_range(TIME_BINS - 1));
      end
    end else if (pick < 92) begin
      r.req = REQ_E_LOAD;
      // near-unity gain keeps most energy hits on the spectrum
      if ($urandom_range(9) != 0) begin
        r.gain = GAIN_W'($urandom_range(8192, 2048));
        r.shv  = SHIFT_W'(int'($urandom_range(1600)) - 800);
      end
    end else if (pick < 98) begin
      r.req = REQ_T_LOAD;
      if ($urandom_range(9) != 0) r.shv = SHIFT_W'(int'($urandom_range(4800)) - 800);
    end else begin
      r.req = ($urandom_range(1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
    end
    return r;
  endfunction

  task automatic offer(input hist_req_t r);
    hit_rec_t h;
    while (!src_steady && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req;
    req_if.detector    <= r.det;
    req_if.raw_value   <= r.raw;
    req_if.dither      <= r.dith;
    req_if.bin_address <= r.addr;
    req_if.gain_value  <= r.gain;
    req_if.shift_value <= r.shv;
    do @(posedge clk); while (!req_if.ready);
    h.det = r.det;
    h.raw = r.raw;
    if (r.req == REQ_E_HIT) begin
      e_recent_hits.push_back(h);
      if (e_recent_hits.size() > 64) void'(e_recent_hits.pop_front());
    end else if (r.req == REQ_T_HIT) begin
      t_recent_hits.push_back(h);
      if (t_recent_hits.size() > 64) void'(t_recent_hits.pop_front());
    end
  endtask

  // stop offering and wait until every outstanding result has been checked
  task automatic drain();
    int n;
    n = 0;
    req_if.valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (results_pending != 0 && n < DRAIN_LIMIT);
  endtask

  // result side: random back-pressure, steady stretches, and counted hold-offs
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= sink_steady || ($urandom_range(99) >= 23);
      end
    end
  end

  initial begin : stimulus
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_E_HIT;
    req_if.detector    <= '0;
    req_if.raw_value   <= '0;
    req_if.dither      <= '0;
    req_if.bin_address <= '0;
    req_if.gain_value  <= '0;
    req_if.shift_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // spectrum edges and calibration corners
    offer(mk(REQ_E_HIT, 0, 0, 0, 0, 0, 0));
    offer(mk(REQ_E_HIT, 31, 4095, 127, 2047, 16'hFFFF, 16'h7FFF));
    offer(mk(REQ_E_HIT, 5, 4094, -128, 0, 0, 0));
    offer(mk(REQ_T_HIT, 0, 4095, 127, 0, 0, 0));
    offer(mk(REQ_T_HIT, 31, 0, -128, 0, 0, 0));
    offer(mk(REQ_E_LOAD, 2, 0, 0, 0, 16'hFFFF, 16'h7FFF));
    offer(mk(REQ_E_HIT, 2, 4095, 127, 0, 0, 0));
    // gain 0 with a -1 channel shift: sum just below zero truncates to bin 0
    offer(mk(REQ_E_LOAD, 3, 0, 0, 0, 0, -16));
    offer(mk(REQ_E_HIT, 3, 1234, -77, 0, 0, 0));
    offer(mk(REQ_E_LOAD, 4, 0, 0, 0, UNITY_GAIN, -32768));
    offer(mk(REQ_E_HIT, 4, 100, 0, 0, 0, 0));
    offer(mk(REQ_T_LOAD, 6, 0, 0, 0, 0, -8));
    offer(mk(REQ_T_HIT, 6, 0, -128, 0, 0, 0));
    offer(mk(REQ_T_LOAD, 7, 0, 0, 0, 0, 32767));
    offer(mk(REQ_T_HIT, 7, 4095, 127, 0, 0, 0));
    offer(mk(REQ_T_LOAD, 9, 0, 0, 0, 0, 8176));
    offer(mk(REQ_T_HIT, 9, 0, 0, 0, 0, 0));
    offer(mk(REQ_T_READ, 9, 0, 0, 511, 0, 0));
    offer(mk(REQ_E_READ, 5, 0, 0, 2047, 0, 0));
    offer(mk(REQ_E_READ, 0, 0, 0, 0, 0, 0));
    offer(mk(REQ_T_READ, 0, 0, 0, 512, 0, 0));
    offer(mk(REQ_T_READ, 1, 0, 0, 2047, 0, 0));
    offer(mk(REQ_SPARE_6, 17, 4095, -1, 2047, 16'hFFFF, 16'hFFFF));
    offer(mk(REQ_SPARE_7, 30, 0, 0, 0, 0, 0));
    drain();

    for (int i = 0; i < 300; i++) offer(random_request());

    // long result hold-off while requests keep coming
    holds_asked++;
    src_steady = 1'b1;
    for (int i = 0; i < 30; i++) offer(random_request());

    sink_steady = 1'b1;
    for (int i = 0; i < 150; i++) offer(random_request());
    src_steady  = 1'b0;
    sink_steady = 1'b0;

    for (int i = 0; i < 270; i++) offer(random_request());

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
